>>> hdl/primality_trial_division_6k_assert.svh
// Assertion macros for the primality tester RTL.
// Depends on nothing; included by the top level, which checks itself.
`ifndef PRIMALITY_TRIAL_DIVISION_6K_ASSERT_SVH
`define PRIMALITY_TRIAL_DIVISION_6K_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTD6_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTD6_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ptd6_pkg.sv
// Shared types and constants for the 6k+-1 trial-division primality tester.
// Depends on nothing.
`default_nettype none

package ptd6_pkg;

  localparam int DEF_VALUE_BITS = 31;

  // Candidate sequence: 5, 11, 17, ... paired with +2.
  localparam int FIRST_CAND = 5;
  localparam int CAND_STEP  = 6;
  localparam int PAIR_GAP   = 2;
  localparam int SMALL_TWO  = 2;
  localparam int SMALL_THREE = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOD3,
    ST_DIV_LO,
    ST_DIV_HI
  } ptd6_state_t;

endpackage

`default_nettype wire

>>> hdl/ptd6_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on nothing outside this file.
`default_nettype none

module ptd6_div #(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  go,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [VALUE_BITS-1:0] divisor,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      quotient,
  output logic [VALUE_BITS-1:0]      remainder
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                  run_r,  run_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r,  cnt_nxt;
  logic [VALUE_BITS-1:0] rem_r,  rem_nxt;
  logic [VALUE_BITS-1:0] quo_r,  quo_nxt;
  logic [VALUE_BITS-1:0] dsr_r,  dsr_nxt;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;

  // The partial remainder takes the next dividend bit from the top of the
  // quotient register, which fills with quotient bits from below.
  assign trial = {rem_r, quo_r[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      quo_nxt = dividend;
      dsr_nxt = divisor;
    end else if (run_r) begin
      if (diff[VALUE_BITS]) begin
        rem_nxt = trial[VALUE_BITS-1:0];
        quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b0};
      end else begin
        rem_nxt = diff[VALUE_BITS-1:0];
        quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(VALUE_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

>>> hdl/primality_trial_division_6k.sv
// Top level of the 6k+-1 trial-division primality tester.
// Depends on ptd6_pkg, ptd6_div and primality_trial_division_6k_assert.svh.
`default_nettype none

// A word is taken on in_value at a rising edge where start is high and busy
// is low, and exactly one result word follows on out_is_prime, marked by
// out_valid for a single cycle. The receiver cannot stall, so it must take
// the result in that cycle. The block works on one word at a time. Values
// below two, two, three and even values are settled in the check state
// without the divider. Every other value needs one division by three and
// then one division per candidate divisor 5, 7, 11, 13, ... up to the
// square root of the value. The worst case is therefore a large prime,
// which runs the full search; the divider's one-bit-per-cycle loop sets
// the cost of each division.

module primality_trial_division_6k #(
  parameter int VALUE_BITS = ptd6_pkg::DEF_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  output logic                       out_is_prime
);

`include "primality_trial_division_6k_assert.svh"

  localparam logic [VALUE_BITS-1:0] C_TWO   = VALUE_BITS'(ptd6_pkg::SMALL_TWO);
  localparam logic [VALUE_BITS-1:0] C_THREE = VALUE_BITS'(ptd6_pkg::SMALL_THREE);
  localparam logic [VALUE_BITS-1:0] C_FIRST = VALUE_BITS'(ptd6_pkg::FIRST_CAND);
  localparam logic [VALUE_BITS-1:0] C_GAP   = VALUE_BITS'(ptd6_pkg::PAIR_GAP);
  localparam logic [VALUE_BITS-1:0] C_STEP  = VALUE_BITS'(ptd6_pkg::CAND_STEP);

  ptd6_pkg::ptd6_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [VALUE_BITS-1:0] cand_r, cand_nxt;
  logic                  res_valid_r, res_valid_nxt;
  logic                  res_prime_r, res_prime_nxt;

  logic                  accept;
  logic                  div_go;
  logic [VALUE_BITS-1:0] div_divisor;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [VALUE_BITS-1:0] div_rem;
  logic                  rem_zero;
  logic                  past_root;

  assign accept    = start && !busy;
  assign rem_zero  = (div_rem == '0);
  // The loop stops once the candidate exceeds value / candidate, which is
  // the overflow-free form of candidate squared exceeding the value.
  assign past_root = (div_quo < cand_r);

  ptd6_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (val_r),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptd6_pkg::ST_IDLE: begin
        if (accept) state_nxt = ptd6_pkg::ST_CHECK;
      end
      ptd6_pkg::ST_CHECK: begin
        priority if (val_r < C_TWO || val_r == C_TWO || val_r == C_THREE || !val_r[0]) begin
          state_nxt = ptd6_pkg::ST_IDLE;
        end else begin
          state_nxt = ptd6_pkg::ST_MOD3;
        end
      end
      ptd6_pkg::ST_MOD3: begin
        if (div_done) begin
          state_nxt = rem_zero ? ptd6_pkg::ST_IDLE : ptd6_pkg::ST_DIV_LO;
        end
      end
      ptd6_pkg::ST_DIV_LO: begin
        if (div_done) begin
          state_nxt = (past_root || rem_zero) ? ptd6_pkg::ST_IDLE : ptd6_pkg::ST_DIV_HI;
        end
      end
      ptd6_pkg::ST_DIV_HI: begin
        if (div_done) begin
          state_nxt = rem_zero ? ptd6_pkg::ST_IDLE : ptd6_pkg::ST_DIV_LO;
        end
      end
      default: state_nxt = ptd6_pkg::ST_IDLE;
    endcase
  end

  // Output and datapath control.
  always_comb begin
    val_nxt       = val_r;
    cand_nxt      = cand_r;
    res_valid_nxt = 1'b0;
    res_prime_nxt = res_prime_r;
    div_go        = 1'b0;
    div_divisor   = cand_r;
    unique case (state_r)
      ptd6_pkg::ST_IDLE: begin
        if (accept) val_nxt = in_value;
      end
      ptd6_pkg::ST_CHECK: begin
        // Zero and one are not prime, two and three are, and other even
        // values are composite; anything else goes to the divider.
        priority if (val_r < C_TWO) begin
          res_valid_nxt = 1'b1;
          res_prime_nxt = 1'b0;
        end else if (val_r == C_TWO || val_r == C_THREE) begin
          res_valid_nxt = 1'b1;
          res_prime_nxt = 1'b1;
        end else if (!val_r[0]) begin
          res_valid_nxt = 1'b1;
          res_prime_nxt = 1'b0;
        end else begin
          div_go      = 1'b1;
          div_divisor = C_THREE;
        end
      end
      ptd6_pkg::ST_MOD3: begin
        if (div_done) begin
          if (rem_zero) begin
            res_valid_nxt = 1'b1;
            res_prime_nxt = 1'b0;
          end else begin
            cand_nxt    = C_FIRST;
            div_go      = 1'b1;
            div_divisor = C_FIRST;
          end
        end
      end
      ptd6_pkg::ST_DIV_LO: begin
        if (div_done) begin
          priority if (past_root) begin
            res_valid_nxt = 1'b1;
            res_prime_nxt = 1'b1;
          end else if (rem_zero) begin
            res_valid_nxt = 1'b1;
            res_prime_nxt = 1'b0;
          end else begin
            div_go      = 1'b1;
            div_divisor = cand_r + C_GAP;
          end
        end
      end
      ptd6_pkg::ST_DIV_HI: begin
        if (div_done) begin
          if (rem_zero) begin
            res_valid_nxt = 1'b1;
            res_prime_nxt = 1'b0;
          end else begin
            cand_nxt    = cand_r + C_STEP;
            div_go      = 1'b1;
            div_divisor = cand_r + C_STEP;
          end
        end
      end
      default: begin
        res_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptd6_pkg::ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    cand_r      <= cand_nxt;
    res_prime_r <= res_prime_nxt;
  end

  assign busy         = (state_r != ptd6_pkg::ST_IDLE);
  assign out_valid    = res_valid_r;
  assign out_is_prime = res_prime_r;

  // A result strobe lasts one cycle, since each word yields one result.
  `PTD6_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "result strobe held for more than one cycle")
  // A result only appears once the tester has gone back to idle.
  `PTD6_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid, !busy, "result shown while still busy")
  // Accepting a word makes the block busy in the next cycle.
  `PTD6_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "accepted word did not start work")
  // The divider only finishes while the sequencer is waiting for it.
  `PTD6_ASSERT_NOW(a_div_owned, clk, rst_n, div_done, state_r == ptd6_pkg::ST_MOD3 || state_r == ptd6_pkg::ST_DIV_LO || state_r == ptd6_pkg::ST_DIV_HI, "divider finished outside a division state")
  // Trial candidates of the form 6k-1 are always odd.
  `PTD6_ASSERT_NOW(a_cand_odd, clk, rst_n, state_r == ptd6_pkg::ST_DIV_LO || state_r == ptd6_pkg::ST_DIV_HI, cand_r[0], "even trial candidate")

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the 6k+-1 trial-division primality tester.
// Depends on ptd6_pkg and primality_trial_division_6k, which needs ptd6_div and the assertion header.
`default_nettype none

module testbench;

  import ptd6_pkg::*;

  localparam int VB = DEF_VALUE_BITS;

  // Allowance for one division in the block's bit-serial divider.
  localparam int DIV_CYCLES = VB + 1;

  // Sender idling, in percent, for each random phase. The third phase stands
  // for the stalling receiver. This block's receiver cannot hold results off,
  // so that phase runs with no idling at all.
  localparam int PHASES = 4;
  localparam int PHASE_WORDS = 19;

  // One word waiting to go in, with the way it is to be sent.
  typedef struct {
    logic [VB-1:0] value;
    int            idle_pct;
    bit            drain_first;
  } trial_word_t;

  // One accepted word and the verdict it should get.
  typedef struct {
    logic [VB-1:0] value;
    bit            verdict;
  } verdict_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic [VB-1:0] in_value = '0;
  wire logic     busy;
  wire logic     out_valid;
  wire logic     out_is_prime;

  trial_word_t words_to_send[$];
  verdict_t    verdicts_due[$];

  // The driver counts accepted words and the monitor counts results. Both
  // change through nonblocking assignments, so either block sees the other's
  // count as it stood before the edge.
  int          words_sent = 0;
  int          results_seen = 0;
  int          mismatch_count = 0;
  longint      cycle_count = 0;
  longint      cycle_limit = 64'd1 << 40;

  primality_trial_division_6k #(
    .VALUE_BITS(VB)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_is_prime (out_is_prime)
  );

  always #1 clk = ~clk;

  // Predicted verdict for one value. Two and three are prime; other multiples
  // of two or three are not. Everything else is tried against d and d + 2
  // for d = 5, 11, 17, ... while d does not exceed value / d, which keeps the
  // bound free of overflow.
  function automatic bit prime_by_6k_trial(logic [VB-1:0] value);
    longint unsigned v;
    longint unsigned d;
    v = 64'(value);
    if (v < 2) begin
      return 1'b0;
    end
    if (v == SMALL_TWO || v == SMALL_THREE) begin
      return 1'b1;
    end
    if (v % SMALL_TWO == 0 || v % SMALL_THREE == 0) begin
      return 1'b0;
    end
    for (d = FIRST_CAND; d <= v / d; d += CAND_STEP) begin
      if (v % d == 0 || v % (d + PAIR_GAP) == 0) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Rough cycle cost of one word in the slowest case, where every candidate
  // up to the square root has to be tried, plus room for the sender's gaps.
  function automatic longint word_cost(logic [VB-1:0] value);
    longint root;
    root = longint'($sqrt(real'(value)));
    return longint'(DIV_CYCLES) * (4 + root / 3) + 200;
  endfunction

  task automatic flag_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic queue_word(logic [VB-1:0] value, int idle_pct, bit drain_first);
    trial_word_t w;
    w.value = value;
    w.idle_pct = idle_pct;
    w.drain_first = drain_first;
    words_to_send.push_back(w);
    cycle_limit += word_cost(value);
  endtask

  // Driver. At each edge it first notes whether the word on the pins was
  // taken, then decides afresh what to put on them for the next cycle, so
  // that start gets exactly one assignment per edge.
  always @(posedge clk) begin : drive_words
    bit       taken;
    bit       go;
    int       sent_after;
    verdict_t entry;
    if (!rst_n) begin
      start <= 1'b0;
      in_value <= '0;
    end else begin
      taken = start && !busy;
      sent_after = words_sent;
      if (taken) begin
        entry.value = in_value;
        entry.verdict = prime_by_6k_trial(in_value);
        verdicts_due.push_back(entry);
        void'(words_to_send.pop_front());
        sent_after = words_sent + 1;
        words_sent <= sent_after;
      end
      go = 1'b0;
      if (words_to_send.size() != 0) begin
        go = ($urandom_range(0, 99) >= words_to_send[0].idle_pct);
        // A draining word holds back until every verdict owed has come out.
        if (words_to_send[0].drain_first && sent_after != results_seen) begin
          go = 1'b0;
        end
      end
      start <= go;
      if (go) begin
        in_value <= words_to_send[0].value;
      end
    end
  end

  // Monitor. The receiver cannot stall, so every strobe is a result word
  // that has to match the oldest verdict still owed.
  always @(posedge clk) begin : check_results
    verdict_t entry;
    if (rst_n && out_valid) begin
      if (results_seen >= words_sent) begin
        flag_mismatch($sformatf("result %0b with no word outstanding", out_is_prime));
      end else begin
        entry = verdicts_due[results_seen];
        if (out_is_prime !== entry.verdict) begin
          flag_mismatch($sformatf("value %0d: is_prime %0b, predicted %0b",
                                  entry.value, out_is_prime, entry.verdict));
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog. The limit is built up from the cost of every queued word and
  // then taken four times over.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= cycle_limit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned small_primes[12];
    int          idle_by_phase[PHASES];
    int          ph;
    int          n;
    int          pick;
    int unsigned p;
    longint      v;
    logic [VB-1:0] w;

    small_primes = '{5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43};
    idle_by_phase = '{0, 60, 0, 34};
    cycle_limit = 0;

    // Directed words, sent without idling. They cover zero and one, the two
    // small primes, plain multiples of two and three, squares of a candidate
    // sitting exactly on the loop bound, factors found by the first and by
    // the second member of a pair, primes just past a square, and the top of
    // the range, whose all-ones value is itself prime and is the slowest word.
    queue_word(0, 0, 1'b0);
    queue_word(1, 0, 1'b0);
    queue_word(2, 0, 1'b0);
    queue_word(3, 0, 1'b0);
    queue_word(4, 0, 1'b0);
    queue_word(5, 0, 1'b0);
    queue_word(6, 0, 1'b0);
    queue_word(7, 0, 1'b0);
    queue_word(9, 0, 1'b0);
    queue_word(25, 0, 1'b0);
    queue_word(29, 0, 1'b0);
    queue_word(35, 0, 1'b0);
    queue_word(49, 0, 1'b0);
    queue_word(77, 0, 1'b0);
    queue_word(121, 0, 1'b0);
    queue_word(143, 0, 1'b0);
    queue_word(169, 0, 1'b0);
    queue_word(961, 0, 1'b0);
    queue_word(997, 0, 1'b0);
    queue_word('1, 0, 1'b1);
    queue_word(VB'({VB{1'b1}} - 1), 0, 1'b0);
    queue_word(VB'({VB{1'b1}} - 2), 0, 1'b0);
    queue_word(VB'({(VB + 1) / 2{2'b01}}), 0, 1'b0);
    queue_word(VB'({(VB + 1) / 2{2'b10}}), 0, 1'b0);

    // Random words. Large odd values that might be prime would need the full
    // search, so large values are built with a known small factor; the
    // costly full searches stay among small and middling values.
    for (ph = 0; ph < PHASES; ph++) begin
      for (n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          w = VB'($urandom_range(0, 4095));
        end else if (pick < 60) begin
          w = VB'($urandom_range(4096, 1 << 20) | 1);
        end else if (pick < 70) begin
          // Large and even.
          w = VB'($urandom) & ~VB'(1);
        end else if (pick < 80) begin
          // Large multiple of three.
          w = VB'($urandom);
          w = w - VB'(w % SMALL_THREE);
        end else begin
          // Large multiple of a small prime, whose factor the search finds early.
          p = small_primes[$urandom_range(0, 11)];
          v = longint'(p) * longint'($urandom_range(1, ((1 << VB) - 1) / p));
          w = VB'(v);
        end
        // Each phase opens with a full drain, and now and then a word in the
        // middle of a phase waits for the block to empty as well.
        queue_word(w, idle_by_phase[ph], n == 0 || $urandom_range(0, 9) == 0);
      end
    end

    cycle_limit = 4 * cycle_limit + 100000;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(posedge clk);
    end while (words_to_send.size() != 0 || results_seen != words_sent);

    // Let a stray extra result show itself before the verdict is given.
    repeat (2 * DIV_CYCLES + 16) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
